// ===== hdl/rpn_pkg.sv =====
`default_nettype none

package rpn_pkg;

  // Stack geometry and value format.
  localparam int STACK_DEPTH   = 16;
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int VALUE_W       = 32;
  localparam int FRAC_W        = 16;
  localparam int DIVIDEND_W    = VALUE_W + FRAC_W;
  localparam int COUNT_FIELD_W = 5;

  // Command codes.
  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;
  localparam logic [2:0] CMD_SHOW  = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_UNDER   = 2'd2;
  localparam logic [1:0] ST_OVER    = 2'd3;

  typedef struct packed {
    logic [2:0]                cmd;
    logic signed [VALUE_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] result_value;
    logic                      has_value;
    logic [COUNT_FIELD_W-1:0]  stack_count;
    logic                      is_last;
  } res_t;

  // Microcode field codes.
  localparam int UPC_W = 5;

  localparam logic [2:0] C_NEXT     = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_FULL     = 3'd2;
  localparam logic [2:0] C_UNDER    = 3'd3;
  localparam logic [2:0] C_EMPTY    = 3'd4;
  localparam logic [2:0] C_RHS_ZERO = 3'd5;
  localparam logic [2:0] C_DIV_BUSY = 3'd6;
  localparam logic [2:0] C_MORE     = 3'd7;

  localparam logic [1:0] RD_TOP    = 2'd0;
  localparam logic [1:0] RD_SECOND = 2'd1;
  localparam logic [1:0] RD_WALK   = 2'd2;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_PUSH = 2'd1;
  localparam logic [1:0] WR_RES  = 2'd2;

  localparam logic [1:0] SEL_ADD = 2'd0;
  localparam logic [1:0] SEL_SUB = 2'd1;
  localparam logic [1:0] SEL_MUL = 2'd2;
  localparam logic [1:0] SEL_DIV = 2'd3;

  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_STATUS = 2'd1;
  localparam logic [1:0] E_RES    = 2'd2;
  localparam logic [1:0] E_WALK   = 2'd3;

  typedef struct packed {
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
    logic [1:0]       rd;
    logic             ld_rhs;
    logic             ld_lhs;
    logic             mul_ld;
    logic             div_start;
    logic             ld_res;
    logic [1:0]       res_sel;
    logic [1:0]       wr;
    logic             clr;
    logic [1:0]       emit;
    logic [1:0]       st;
    logic             walk_clr;
    logic             walk_inc;
    logic             fin;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic under;
    logic empty;
    logic rhs_zero;
    logic div_busy;
    logic more;
  } flags_t;

  // Microprogram addresses.
  localparam logic [UPC_W-1:0] U_PUSH0  = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_PUSH1  = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_ADD0   = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_ADD1   = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_ADD2   = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_ADD3   = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_SUB0   = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_SUB1   = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_SUB2   = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_SUB3   = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_MUL0   = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_MUL1   = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_MUL2   = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_MUL3   = UPC_W'(13);
  localparam logic [UPC_W-1:0] U_MUL4   = UPC_W'(14);
  localparam logic [UPC_W-1:0] U_DIV0   = UPC_W'(15);
  localparam logic [UPC_W-1:0] U_DIV1   = UPC_W'(16);
  localparam logic [UPC_W-1:0] U_DIV2   = UPC_W'(17);
  localparam logic [UPC_W-1:0] U_DIV3   = UPC_W'(18);
  localparam logic [UPC_W-1:0] U_DIV4   = UPC_W'(19);
  localparam logic [UPC_W-1:0] U_DIV5   = UPC_W'(20);
  localparam logic [UPC_W-1:0] U_DIV6   = UPC_W'(21);
  localparam logic [UPC_W-1:0] U_WB0    = UPC_W'(22);
  localparam logic [UPC_W-1:0] U_WB1    = UPC_W'(23);
  localparam logic [UPC_W-1:0] U_CLR0   = UPC_W'(24);
  localparam logic [UPC_W-1:0] U_OK     = UPC_W'(25);
  localparam logic [UPC_W-1:0] U_SHOW0  = UPC_W'(26);
  localparam logic [UPC_W-1:0] U_SHOW1  = UPC_W'(27);
  localparam logic [UPC_W-1:0] U_SHOW2  = UPC_W'(28);
  localparam logic [UPC_W-1:0] U_OVF    = UPC_W'(29);
  localparam logic [UPC_W-1:0] U_UND    = UPC_W'(30);
  localparam logic [UPC_W-1:0] U_DZ     = UPC_W'(31);

  // Control store: one control word per microprogram step.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    w = '0;
    unique case (addr) inside
      U_PUSH0: begin
        w.cond = C_FULL;
        w.target = U_OVF;
      end
      U_PUSH1: begin
        w.wr = WR_PUSH;
        w.cond = C_ALWAYS;
        w.target = U_OK;
      end
      U_ADD0, U_SUB0, U_MUL0, U_DIV0: begin
        w.rd = RD_TOP;
        w.cond = C_UNDER;
        w.target = U_UND;
      end
      U_ADD1, U_SUB1, U_MUL1, U_DIV1: begin
        w.rd = RD_SECOND;
        w.ld_rhs = 1'b1;
      end
      U_ADD2, U_SUB2, U_MUL2, U_DIV2: begin
        w.ld_lhs = 1'b1;
      end
      U_ADD3: begin
        w.ld_res = 1'b1;
        w.res_sel = SEL_ADD;
        w.cond = C_ALWAYS;
        w.target = U_WB0;
      end
      U_SUB3: begin
        w.ld_res = 1'b1;
        w.res_sel = SEL_SUB;
        w.cond = C_ALWAYS;
        w.target = U_WB0;
      end
      U_MUL3: begin
        w.mul_ld = 1'b1;
      end
      U_MUL4: begin
        w.ld_res = 1'b1;
        w.res_sel = SEL_MUL;
        w.cond = C_ALWAYS;
        w.target = U_WB0;
      end
      U_DIV3: begin
        w.cond = C_RHS_ZERO;
        w.target = U_DZ;
      end
      U_DIV4: begin
        w.div_start = 1'b1;
      end
      U_DIV5: begin
        w.cond = C_DIV_BUSY;
        w.target = U_DIV5;
      end
      U_DIV6: begin
        w.ld_res = 1'b1;
        w.res_sel = SEL_DIV;
        w.cond = C_ALWAYS;
        w.target = U_WB0;
      end
      U_WB0: begin
        w.wr = WR_RES;
      end
      U_WB1: begin
        w.emit = E_RES;
        w.st = ST_OK;
        w.fin = 1'b1;
      end
      U_CLR0: begin
        w.clr = 1'b1;
      end
      U_OK: begin
        w.emit = E_STATUS;
        w.st = ST_OK;
        w.fin = 1'b1;
      end
      U_SHOW0: begin
        w.walk_clr = 1'b1;
        w.cond = C_EMPTY;
        w.target = U_OK;
      end
      U_SHOW1: begin
        w.rd = RD_WALK;
      end
      U_SHOW2: begin
        w.emit = E_WALK;
        w.st = ST_OK;
        w.walk_inc = 1'b1;
        w.cond = C_MORE;
        w.target = U_SHOW1;
        w.fin = 1'b1;
      end
      U_OVF: begin
        w.emit = E_STATUS;
        w.st = ST_OVER;
        w.fin = 1'b1;
      end
      U_UND: begin
        w.emit = E_STATUS;
        w.st = ST_UNDER;
        w.fin = 1'b1;
      end
      U_DZ: begin
        w.emit = E_STATUS;
        w.st = ST_DIVZERO;
        w.fin = 1'b1;
      end
      default: begin
        w.emit = E_STATUS;
        w.st = ST_OK;
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rpn_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rpn_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [rpn_pkg::DIVIDEND_W-1:0]      dividend,
  input  wire logic [rpn_pkg::VALUE_W-1:0]         divisor,
  output logic      [rpn_pkg::DIVIDEND_W-1:0]      quotient,
  output logic                                     busy
);

  localparam int STEP_W = $clog2(rpn_pkg::DIVIDEND_W);
  localparam int MSB    = rpn_pkg::DIVIDEND_W - 1;

  logic [rpn_pkg::DIVIDEND_W-1:0] quo;
  logic [rpn_pkg::VALUE_W-1:0]    rem;
  logic [rpn_pkg::VALUE_W-1:0]    dsr;
  logic [STEP_W-1:0]              cnt;
  logic [rpn_pkg::VALUE_W:0]      trial;

  assign trial    = {rem, quo[MSB]} - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == STEP_W'(MSB)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= '0;
    end else if (busy) begin
      if (!trial[rpn_pkg::VALUE_W]) begin
        rem <= trial[rpn_pkg::VALUE_W-1:0];
      end else begin
        rem <= {rem[rpn_pkg::VALUE_W-2:0], quo[MSB]};
      end
      quo <= {quo[MSB-1:0], ~trial[rpn_pkg::VALUE_W]};
      cnt <= cnt + STEP_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpn_seq.sv =====
`default_nettype none

// Microprogram sequencer: step counter, dispatch and conditional jumps.
module rpn_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2:0]      cmd,
  input  wire rpn_pkg::flags_t flags,
  output rpn_pkg::ctrl_t       ctrl,
  output logic                 busy
);

  logic [rpn_pkg::UPC_W-1:0] upc;
  logic [rpn_pkg::UPC_W-1:0] entry;
  rpn_pkg::ctrl_t            word;
  logic                      taken;

  always_comb begin
    unique case (cmd)
      rpn_pkg::CMD_PUSH:  entry = rpn_pkg::U_PUSH0;
      rpn_pkg::CMD_ADD:   entry = rpn_pkg::U_ADD0;
      rpn_pkg::CMD_SUB:   entry = rpn_pkg::U_SUB0;
      rpn_pkg::CMD_MUL:   entry = rpn_pkg::U_MUL0;
      rpn_pkg::CMD_DIV:   entry = rpn_pkg::U_DIV0;
      rpn_pkg::CMD_CLEAR: entry = rpn_pkg::U_CLR0;
      rpn_pkg::CMD_SHOW:  entry = rpn_pkg::U_SHOW0;
      default:            entry = rpn_pkg::U_OK;
    endcase
  end

  assign word = rpn_pkg::ucode(upc);
  assign ctrl = busy ? word : '0;

  always_comb begin
    unique case (word.cond)
      rpn_pkg::C_NEXT:     taken = 1'b0;
      rpn_pkg::C_ALWAYS:   taken = 1'b1;
      rpn_pkg::C_FULL:     taken = flags.full;
      rpn_pkg::C_UNDER:    taken = flags.under;
      rpn_pkg::C_EMPTY:    taken = flags.empty;
      rpn_pkg::C_RHS_ZERO: taken = flags.rhs_zero;
      rpn_pkg::C_DIV_BUSY: taken = flags.div_busy;
      rpn_pkg::C_MORE:     taken = flags.more;
      default:             taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        upc  <= entry;
      end
    end else if (taken) begin
      upc <= word.target;
    end else if (word.fin) begin
      busy <= 1'b0;
    end else begin
      upc <= upc + rpn_pkg::UPC_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpn_dp.sv =====
`default_nettype none

// Datapath: operand stack memory, operand registers, arithmetic and result register.
module rpn_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [rpn_pkg::VALUE_W-1:0]    operand,
  input  wire rpn_pkg::ctrl_t                 ctrl,
  output rpn_pkg::flags_t                     flags,
  output rpn_pkg::res_t                       result,
  output logic                                result_valid
);

  localparam int VW = rpn_pkg::VALUE_W;
  localparam int AW = rpn_pkg::ADDR_W;
  localparam int CW = rpn_pkg::CNT_W;
  localparam int DW = rpn_pkg::DIVIDEND_W;

  logic [VW-1:0]   mem [rpn_pkg::STACK_DEPTH];
  logic [VW-1:0]   mem_q;
  logic [VW-1:0]   opnd;
  logic [VW-1:0]   lhs;
  logic [VW-1:0]   rhs;
  logic [2*VW-1:0] prod;
  logic [VW-1:0]   res;
  logic [CW-1:0]   count;
  logic [AW-1:0]   walk;

  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [VW-1:0]   wr_data;
  logic [CW-1:0]   count_m1;
  logic [CW-1:0]   count_m2;
  logic [VW-1:0]   lhs_mag;
  logic [VW-1:0]   rhs_mag;
  logic            neg;
  logic [VW:0]     sum;
  logic [VW:0]     diff;
  logic [DW-1:0]   quotient;
  logic            div_busy;
  logic [VW-1:0]   res_next;
  logic            walk_last;

  function automatic logic [VW-1:0] mag(input logic [VW-1:0] x);
    return x[VW-1] ? (~x + VW'(1)) : x;
  endfunction

  function automatic logic [VW-1:0] sat_wide(input logic [VW:0] v);
    if (v[VW] != v[VW-1]) begin
      return v[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return v[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_signmag(input logic n, input logic [DW-1:0] m);
    logic [DW-1:0] lim;
    logic [VW-1:0] q;
    if (n) begin
      lim = DW'({1'b1, {(VW-1){1'b0}}});
      q   = (m > lim) ? lim[VW-1:0] : m[VW-1:0];
      return ~q + VW'(1);
    end
    lim = DW'({1'b0, {(VW-1){1'b1}}});
    return (m > lim) ? lim[VW-1:0] : m[VW-1:0];
  endfunction

  assign count_m1  = count - CW'(1);
  assign count_m2  = count - CW'(2);
  assign lhs_mag   = mag(lhs);
  assign rhs_mag   = mag(rhs);
  assign neg       = lhs[VW-1] ^ rhs[VW-1];
  assign sum       = {lhs[VW-1], lhs} + {rhs[VW-1], rhs};
  assign diff      = {lhs[VW-1], lhs} - {rhs[VW-1], rhs};
  assign walk_last = CW'(walk) == count_m1;

  assign flags.full     = count >= CW'(rpn_pkg::STACK_DEPTH);
  assign flags.under    = count < CW'(2);
  assign flags.empty    = count == '0;
  assign flags.rhs_zero = rhs == '0;
  assign flags.div_busy = div_busy;
  assign flags.more     = !walk_last;

  always_comb begin
    case (ctrl.rd)
      rpn_pkg::RD_SECOND: rd_addr = count_m2[AW-1:0];
      rpn_pkg::RD_WALK:   rd_addr = walk;
      default:            rd_addr = count_m1[AW-1:0];
    endcase
  end

  assign wr_addr = (ctrl.wr == rpn_pkg::WR_PUSH) ? count[AW-1:0] : count_m2[AW-1:0];
  assign wr_data = (ctrl.wr == rpn_pkg::WR_PUSH) ? opnd : res;

  always_ff @(posedge clk) begin
    if (ctrl.wr != rpn_pkg::WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    case (ctrl.res_sel)
      rpn_pkg::SEL_ADD: res_next = sat_wide(sum);
      rpn_pkg::SEL_SUB: res_next = sat_wide(diff);
      rpn_pkg::SEL_MUL: res_next = sat_signmag(neg, prod[2*VW-1:rpn_pkg::FRAC_W]);
      default:          res_next = sat_signmag(neg, quotient);
    endcase
  end

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend ({lhs_mag, {rpn_pkg::FRAC_W{1'b0}}}),
    .divisor  (rhs_mag),
    .quotient (quotient),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      opnd <= operand;
    end
    if (ctrl.ld_rhs) begin
      rhs <= mem_q;
    end
    if (ctrl.ld_lhs) begin
      lhs <= mem_q;
    end
    if (ctrl.mul_ld) begin
      prod <= {{VW{1'b0}}, lhs_mag} * {{VW{1'b0}}, rhs_mag};
    end
    if (ctrl.ld_res) begin
      res <= res_next;
    end
    if (ctrl.walk_clr) begin
      walk <= '0;
    end else if (ctrl.walk_inc) begin
      walk <= walk + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clr) begin
      count <= '0;
    end else if (ctrl.wr == rpn_pkg::WR_PUSH) begin
      count <= count + CW'(1);
    end else if (ctrl.wr == rpn_pkg::WR_RES) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit != rpn_pkg::E_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit != rpn_pkg::E_NONE) begin
      result.status      <= ctrl.st;
      result.stack_count <= rpn_pkg::COUNT_FIELD_W'(count);
      case (ctrl.emit)
        rpn_pkg::E_RES: begin
          result.result_value <= res;
          result.has_value    <= 1'b1;
          result.is_last      <= 1'b1;
        end
        rpn_pkg::E_WALK: begin
          result.result_value <= mem_q;
          result.has_value    <= 1'b1;
          result.is_last      <= walk_last;
        end
        default: begin
          result.result_value <= '0;
          result.has_value    <= 1'b0;
          result.is_last      <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpn_stack_calculator.sv =====
`default_nettype none

// Reverse Polish calculator on a stack of signed Q16.16 values.
// Request channel: drive request (cmd, operand) and raise start; the request
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the microprogram for that request has finished.
// Result channel: every result shows on result for one cycle with
// result_valid high. There is no back pressure; the receiver must take each
// result in the cycle it appears. Results come in the cycle after the
// microprogram step that produces them, in order.
// The divide runs on the restoring divider, which makes one quotient bit
// per cycle over 48 bits while the microprogram waits on its busy flag;
// show is paced by the single read port of the stack memory, with a read
// step and an emit step per entry. Everything else is the step count of
// the microprogram.
// Reset (rst, synchronous) empties the stack, stops the sequencer and drops
// result_valid; stack contents are not cleared and are never read before
// being written.
module rpn_stack_calculator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rpn_pkg::req_t request,
  output logic               busy,
  output rpn_pkg::res_t      result,
  output logic               result_valid
);

  rpn_pkg::ctrl_t  ctrl;
  rpn_pkg::flags_t flags;
  logic            accept;

  // A request is taken only while the sequencer is idle.
  assign accept = start && !busy;

  // The sequencer steps through the control store; each word drives the datapath
  // and the datapath returns the condition flags for jumps.
  rpn_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (request.cmd),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // The datapath holds the stack, the operand registers, the multiplier, the
  // divider and the registered result port.
  rpn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operand      (request.operand),
    .ctrl         (ctrl),
    .flags        (flags),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

// ===== hdl/rpn_chk.sv =====
`default_nettype none

module rpn_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire rpn_pkg::res_t result,
  input wire logic          result_valid
);

  // An accepted request keeps the block busy for at least its first step.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result that is not the last one of its request arrives while busy.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_last |-> busy)
    else $error("non-final result while idle");

  // Each show result that is not the last is followed by another one.
  a_show_pace: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_last |-> ##2 result_valid)
    else $error("show result sequence broken");

  // Errors never carry a value.
  a_err_noval: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != rpn_pkg::ST_OK |-> !result.has_value)
    else $error("error result carries a value");

  // The reported count never exceeds the stack depth.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.stack_count <= rpn_pkg::COUNT_FIELD_W'(rpn_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

endmodule

bind rpn_stack_calculator rpn_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);

`default_nettype wire

// ===== verif/rpn_stack_calculator_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the Q16.16 RPN calculator. A directed table goes
// first, then random command sequences. Every accepted request runs through
// a behavioral copy of the calculator kept here. Each result the block
// strobes out is checked field by field against the oldest expected entry.
module rpn_stack_calculator_tb;
  import rpn_pkg::*;

  // The command field has room for one code the block does not use. It
  // must be ignored, and it still answers with a plain OK.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam int CYCLE_LIMIT  = 300000;
  // The slowest command is a divide. The tail wait is longer than a
  // divide takes, so that a stray result after the last expected one is
  // still caught.
  localparam int TAIL_CYCLES  = 100;
  localparam int RANDOM_ITEMS = 90;
  localparam int PRINT_CAP    = 40;

  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

  // One row of the directed table. When typed is set, want is the one
  // result that the request must give. Otherwise the predictor supplies
  // the expectation.
  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  res_t result;
  logic result_valid;

  // These travel with each request, so that the monitor knows at the
  // accepting edge whether a typed expectation replaces the predicted one.
  bit   row_typed = 1'b0;
  res_t row_want = '0;

  // Copy of the operand stack that the predictor keeps.
  logic signed [VALUE_W-1:0] calc_stack[STACK_DEPTH];
  int calc_depth = 0;

  res_t step_results[$];
  res_t pending[$];

  dir_row_t dir_rows[$];

  int mismatches     = 0;
  int results_seen   = 0;
  int error_results  = 0;
  int accepted       = 0;
  int random_count   = 0;
  int burst_left     = 0;
  int cycle_count    = 0;

  rpn_stack_calculator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------

  function automatic logic [63:0] magnitude(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // Clamp a sign and magnitude pair to the 32-bit two's complement range.
  function automatic logic [31:0] saturate(input bit neg, input logic [63:0] mag);
    logic [63:0] wide;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      wide = 64'd0 - mag;
      return wide[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // The stack count goes out as it stands after the command.
  task automatic post_result(input logic [1:0] st, input logic [31:0] val,
                             input logic has, input logic last);
    res_t r;
    r.status       = st;
    r.result_value = val;
    r.has_value    = has;
    r.stack_count  = COUNT_FIELD_W'(calc_depth);
    r.is_last      = last;
    step_results.push_back(r);
  endtask

  // Apply one request to the stack copy and collect the results it gives.
  task automatic calc_step(input req_t r);
    longint      lhs;
    longint      rhs;
    logic [63:0] lmag;
    logic [63:0] rmag;
    logic [31:0] val;
    bit          neg;
    step_results.delete();
    case (r.cmd)
      CMD_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          post_result(ST_OVER, '0, 1'b0, 1'b1);
        end else begin
          calc_stack[calc_depth] = r.operand;
          calc_depth++;
          post_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (calc_depth < 2) begin
          post_result(ST_UNDER, '0, 1'b0, 1'b1);
        end else begin
          // The right operand sits on top and the left one just below it.
          rhs  = calc_stack[calc_depth-1];
          lhs  = calc_stack[calc_depth-2];
          lmag = magnitude(lhs);
          rmag = magnitude(rhs);
          neg  = (lhs < 0) != (rhs < 0);
          if (r.cmd == CMD_DIV && rhs == 0) begin
            post_result(ST_DIVZERO, '0, 1'b0, 1'b1);
          end else begin
            case (r.cmd)
              CMD_ADD: val = saturate(lhs + rhs < 0, magnitude(lhs + rhs));
              CMD_SUB: val = saturate(lhs - rhs < 0, magnitude(lhs - rhs));
              CMD_MUL: val = saturate(neg, (lmag * rmag) >> FRAC_W);
              default: val = saturate(neg, (lmag << FRAC_W) / rmag);
            endcase
            calc_depth--;
            calc_stack[calc_depth-1] = val;
            post_result(ST_OK, val, 1'b1, 1'b1);
          end
        end
      end
      CMD_CLEAR: begin
        calc_depth = 0;
        post_result(ST_OK, '0, 1'b0, 1'b1);
      end
      CMD_SHOW: begin
        // An empty stack gives one empty marker. Otherwise every entry is
        // listed from the bottom up, and the top one carries is_last.
        if (calc_depth == 0) begin
          post_result(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < calc_depth; i++)
            post_result(ST_OK, calc_stack[i], 1'b1, i == calc_depth - 1);
        end
      end
      default: post_result(ST_OK, '0, 1'b0, 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    results_seen++;
    if (got.status != ST_OK) error_results++;
    if (pending.size() == 0) begin
      report_mismatch("result with nothing pending", got, 0);
    end else begin
      want = pending.pop_front();
      if (got.status != want.status)
        report_mismatch("status", got.status, want.status);
      if (got.result_value != want.result_value)
        report_mismatch("result_value", got.result_value, want.result_value);
      if (got.has_value != want.has_value)
        report_mismatch("has_value", got.has_value, want.has_value);
      if (got.stack_count != want.stack_count)
        report_mismatch("stack_count", got.stack_count, want.stack_count);
      if (got.is_last != want.is_last)
        report_mismatch("is_last", got.is_last, want.is_last);
    end
  endtask

  // Outputs are sampled at the rising edge, before that edge updates them.
  // A result that shows at this edge belongs to an earlier request, so it
  // is checked before the expectations of a request taken at the same
  // edge are queued.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) check_result(result);
      if (start && !busy) begin
        accepted++;
        calc_step(request);
        if (row_typed) pending.push_back(row_want);
        else foreach (step_results[i]) pending.push_back(step_results[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------

  // The sender works in bursts. Between bursts it lets start fall for a
  // while: often briefly, sometimes for long enough that the block goes
  // idle. The request is then held until the block takes it. Start stays
  // high from one request to the next inside a burst.
  task automatic send_request(input req_t r, input bit typed, input res_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(16, 80);
        default:       gap = $urandom_range(1, 15);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start     <= 1'b1;
    request   <= r;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!(start && !busy));
  endtask

  task automatic send_random(input logic [2:0] c, input logic [31:0] v);
    req_t r;
    r.cmd     = c;
    r.operand = v;
    // Ignored codes do not count toward the length of the random part.
    if (c != CMD_UNUSED) random_count++;
    send_request(r, 1'b0, '0);
  endtask

  // Half are values of a few units, so that multiply and divide give results
  // in range. The rest are extremes, zero, or any 32-bit pattern.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3, 4:    return $urandom;
      default: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic logic [2:0] rand_operator();
    return 3'($urandom_range(CMD_ADD, CMD_DIV));
  endfunction

  // A directed row whose expectation comes from the predictor.
  function automatic dir_row_t chk(input logic [2:0] c, input logic [31:0] v);
    dir_row_t d;
    d.req.cmd     = c;
    d.req.operand = v;
    d.typed       = 1'b0;
    d.want        = '0;
    return d;
  endfunction

  // A directed row with its single result written out.
  function automatic dir_row_t lit(input logic [2:0] c, input logic [31:0] v,
                                   input logic [1:0] st, input logic [31:0] rv,
                                   input logic hv, input logic [4:0] cnt);
    dir_row_t d;
    d = chk(c, v);
    d.typed             = 1'b1;
    d.want.status       = st;
    d.want.result_value = rv;
    d.want.has_value    = hv;
    d.want.stack_count  = cnt;
    d.want.is_last      = 1'b1;
    return d;
  endfunction

  // The first rows run on an empty stack just out of reset. Operators are
  // tried with too few operands. The sum saturates at both ends and the
  // difference at the top; the product of two minimum values clamps to the
  // maximum. A divide by zero must leave the stack as it was. The unused
  // code must be ignored. Show is tried on one entry and on several.
  initial begin
    dir_rows.push_back(lit(CMD_SHOW,   '0,        ST_OK,      '0,    1'b0, 5'd0));
    dir_rows.push_back(lit(CMD_ADD,    '0,        ST_UNDER,   '0,    1'b0, 5'd0));
    dir_rows.push_back(lit(CMD_PUSH,   Q_MAX,     ST_OK,      '0,    1'b0, 5'd1));
    dir_rows.push_back(lit(CMD_DIV,    '0,        ST_UNDER,   '0,    1'b0, 5'd1));
    dir_rows.push_back(lit(CMD_PUSH,   Q_MAX,     ST_OK,      '0,    1'b0, 5'd2));
    dir_rows.push_back(lit(CMD_ADD,    '1,        ST_OK,      Q_MAX, 1'b1, 5'd1));
    dir_rows.push_back(lit(CMD_PUSH,   Q_MIN,     ST_OK,      '0,    1'b0, 5'd2));
    dir_rows.push_back(lit(CMD_SUB,    '0,        ST_OK,      Q_MAX, 1'b1, 5'd1));
    dir_rows.push_back(lit(CMD_PUSH,   '0,        ST_OK,      '0,    1'b0, 5'd2));
    dir_rows.push_back(lit(CMD_DIV,    '0,        ST_DIVZERO, '0,    1'b0, 5'd2));
    dir_rows.push_back(lit(CMD_UNUSED, '1,        ST_OK,      '0,    1'b0, 5'd2));
    dir_rows.push_back(lit(CMD_MUL,    '0,        ST_OK,      '0,    1'b1, 5'd1));
    dir_rows.push_back(lit(CMD_PUSH,   Q_MIN,     ST_OK,      '0,    1'b0, 5'd2));
    dir_rows.push_back(lit(CMD_PUSH,   Q_MIN,     ST_OK,      '0,    1'b0, 5'd3));
    dir_rows.push_back(lit(CMD_MUL,    '0,        ST_OK,      Q_MAX, 1'b1, 5'd2));
    dir_rows.push_back(lit(CMD_PUSH,   Q_NEG_ONE, ST_OK,      '0,    1'b0, 5'd3));
    dir_rows.push_back(chk(CMD_DIV,    '0));
    dir_rows.push_back(chk(CMD_PUSH,   32'h0001_8000));
    dir_rows.push_back(chk(CMD_SHOW,   '0));
    dir_rows.push_back(lit(CMD_CLEAR,  Q_ONE,     ST_OK,      '0,    1'b0, 5'd0));
    dir_rows.push_back(lit(CMD_PUSH,   Q_MIN,     ST_OK,      '0,    1'b0, 5'd1));
    dir_rows.push_back(lit(CMD_PUSH,   Q_MIN,     ST_OK,      '0,    1'b0, 5'd2));
    dir_rows.push_back(lit(CMD_ADD,    '0,        ST_OK,      Q_MIN, 1'b1, 5'd1));
    dir_rows.push_back(lit(CMD_SHOW,   '0,        ST_OK,      Q_MIN, 1'b1, 5'd1));
  end

  // Watchdog. It ends the run if the block hangs or results go missing.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results still pending",
             cycle_count, pending.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int  n_push;
    int  n_ops;
    bit  first_seq;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // The random part is built from short command sequences. The first
    // one fills the stack to the top, pushes once more to overflow it, and
    // shows all sixteen entries, then applies one to four operators.
    first_seq = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      case (first_seq ? 0 : $urandom_range(0, 11))
        0: begin
          send_random(CMD_CLEAR, $urandom);
          repeat (STACK_DEPTH + 1) send_random(CMD_PUSH, rand_operand());
          send_random(CMD_SHOW, $urandom);
          repeat ($urandom_range(1, 4)) send_random(rand_operator(), $urandom);
        end
        1, 2, 3, 4, 5, 6: begin
          // A small expression: a few operands, then a few operators. The
          // operators sometimes run past what is on the stack.
          n_push = $urandom_range(1, 4);
          n_ops  = $urandom_range(1, n_push + 1);
          repeat (n_push) send_random(CMD_PUSH, rand_operand());
          repeat (n_ops) send_random(rand_operator(), $urandom);
          if ($urandom_range(0, 2) == 0) send_random(CMD_SHOW, $urandom);
        end
        7:    send_random(CMD_SHOW, $urandom);
        8:    send_random(CMD_CLEAR, $urandom);
        default: begin
          // Noise: any command code with any operand.
          repeat ($urandom_range(1, 3)) send_random(3'($urandom_range(0, 7)), $urandom);
        end
      endcase
      first_seq = 1'b0;
    end
    start <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d directed, %0d random), %0d results checked.",
             accepted, dir_rows.size(), random_count, results_seen);
    $display("%0d results carried an error status; %0d mismatches found.",
             error_results, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
